// ----- hdl/sfs_pkg.sv -----
package sfs_pkg;

   localparam int FRAME_BITS    = 8;
   localparam int COUNT_BITS    = 9;
   localparam int TIME_BITS     = 16;
   localparam int ACC_BITS      = 32;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 12;
   localparam int SPEED_BITS    = 12;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_RESET = 3'd3;
   localparam logic [2:0] CMD_SETF  = 3'd4;
   localparam logic [2:0] CMD_WRITE = 3'd5;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPEED  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SINGLE = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TOTAL  = 2'd2;

   localparam logic [SPEED_BITS-1:0] SPEED_UNITY = 12'd256;

   typedef struct packed {
      logic [2:0]            cmd;
      logic [TIME_BITS-1:0]  elapsed_ms;
      logic [FRAME_BITS-1:0] frame_index;
      logic [TIME_BITS-1:0]  duration_ms;
      logic [COUNT_BITS-1:0] loaded_count;
   } req_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] current_frame;
      logic                  playing;
      logic                  finished;
   } rsp_type;

endpackage

// ----- hdl/sfs_div.sv -----
module sfs_div #(
   parameter int DW = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DW-1:0]                dividend,
   input  logic [sfs_pkg::ACC_BITS-1:0] divisor,
   output logic                         done,
   output logic [DW-1:0]                quotient,
   output logic [sfs_pkg::ACC_BITS-1:0] remainder
);
   import sfs_pkg::*;

   localparam int CW = $clog2(DW + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CW-1:0]       cnt_ff;
   logic [DW-1:0]       quo_ff;
   logic [ACC_BITS-1:0] rem_ff;
   logic [ACC_BITS-1:0] div_ff;

   logic [ACC_BITS:0]   trial;
   logic [ACC_BITS:0]   diff;
   logic                fits;
   logic [ACC_BITS-1:0] rem_in;

   // Restoring division, one quotient bit per cycle. The dividend shifts out
   // of the top of quo_ff while quotient bits shift in at the bottom.
   always_comb begin
      trial  = {rem_ff, quo_ff[DW-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? diff[ACC_BITS-1:0] : trial[ACC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hdl/sprite_frame_sequencer.sv -----
// Channel   Direction  Handshake              Moves
// req       in         req_valid/req_ready    one command beat (req_type)
// rsp       out        rsp_valid/rsp_ready    one status beat per command (rsp_type)
// csr       in         csr_we                 register write, no wait
//
// Commands other than tick, and ticks while stopped, go from S_IDLE straight to S_DONE.
// A running tick runs one divider pass for each frame duration it scales, on DW bits, DW
// being the larger of DURATION_BITS+16 and 32: the current frame and every frame stepped.
// Holding a frame, wrapping a frame past the count or folding whole loops adds one more
// divider pass. One command is in flight; its beat waits in the rsp register while the
// next is accepted. Reset is synchronous; the table is not cleared.
module sprite_frame_sequencer #(
   parameter int MAX_FRAMES    = 256,
   parameter int DURATION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sfs_pkg::req_type                  req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sfs_pkg::rsp_type                  rsp_item,
   input  logic                              csr_we,
   input  logic [sfs_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [sfs_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import sfs_pkg::*;

   localparam int TABLE_DEPTH = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
   localparam int AW          = $clog2(TABLE_DEPTH);
   localparam int SW          = DURATION_BITS + 16;
   localparam int DW          = (SW > ACC_BITS) ? SW : ACC_BITS;
   localparam logic [COUNT_BITS-1:0] TOTAL_CAP = COUNT_BITS'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_SDIV, S_STEP, S_MDIV, S_FDIV, S_CYC, S_CDIV, S_ADD, S_DONE
   } state_type;

   logic [DURATION_BITS-1:0] dur_mem [TABLE_DEPTH];
   logic [DURATION_BITS-1:0] rd_data_ff;

   logic [SPEED_BITS-1:0] speed_ff;
   logic                  single_ff;
   logic [COUNT_BITS-1:0] ftotal_ff;

   state_type             state_ff;
   logic [FRAME_BITS-1:0] frame_now_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic                  running_ff;
   logic                  fin_ff;
   logic [TIME_BITS-1:0]  elapsed_ff;
   logic [COUNT_BITS-1:0] loaded_ff;
   logic [ACC_BITS-1:0]   s_ff;
   logic                  s_big_ff;
   logic [ACC_BITS-1:0]   sum_ff;
   logic                  sum_ovf_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_item_ff;

   logic                  req_fire;
   logic [COUNT_BITS-1:0] total_eff;
   logic [SPEED_BITS-1:0] speed_eff;
   logic [COUNT_BITS-1:0] frame_ext;
   logic [COUNT_BITS-1:0] frame_inc;
   logic                  in_range;
   logic [DURATION_BITS-1:0] dur_eff;
   logic                  brk;
   logic                  stop_shot;
   logic                  adv;
   logic                  wrap_slow;
   logic                  cyc_mod;
   logic [ACC_BITS:0]     sum_in;
   logic [ACC_BITS:0]     acc_sum_in;

   logic                  div_start;
   logic [DW-1:0]         div_dividend;
   logic [ACC_BITS-1:0]   div_divisor;
   logic                  div_done;
   logic [DW-1:0]         div_quo;
   logic [ACC_BITS-1:0]   div_rem;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      if (ftotal_ff == '0) begin
         total_eff = COUNT_BITS'(1);
      end else if (ftotal_ff > TOTAL_CAP) begin
         total_eff = TOTAL_CAP;
      end else begin
         total_eff = ftotal_ff;
      end
      speed_eff  = (speed_ff == '0) ? SPEED_BITS'(1) : speed_ff;
      frame_ext  = {1'b0, frame_now_ff};
      frame_inc  = frame_ext + COUNT_BITS'(1);
      in_range   = 32'(frame_now_ff) < MAX_FRAMES;
      dur_eff    = in_range ? rd_data_ff : '0;
      brk        = s_big_ff || (acc_ff <= s_ff);
      stop_shot  = single_ff && (frame_ext == total_eff - COUNT_BITS'(1));
      adv        = (loaded_ff == total_eff) || (frame_inc < loaded_ff);
      wrap_slow  = frame_inc > total_eff;
      // A full loop of the animation has been stepped; whole loops fold away.
      cyc_mod    = (cnt_ff == total_eff) && !sum_ovf_ff && (acc_ff > sum_ff);
      sum_in     = {1'b0, sum_ff} + {1'b0, s_ff};
      acc_sum_in = {1'b0, acc_ff} + {9'b0, elapsed_ff, 8'b0};
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_LOAD: begin
            div_start    = dur_eff != '0;
            div_dividend = DW'({dur_eff, 16'b0});
            div_divisor  = ACC_BITS'(speed_eff);
         end
         S_STEP: begin
            div_start = !brk && !stop_shot && (!adv || wrap_slow);
            if (!adv) begin
               div_dividend = DW'(acc_ff - ACC_BITS'(1));
               div_divisor  = s_ff;
            end else begin
               div_dividend = DW'(frame_inc);
               div_divisor  = ACC_BITS'(total_eff);
            end
         end
         S_CYC: begin
            div_start    = cyc_mod;
            div_dividend = DW'(acc_ff - ACC_BITS'(1));
            div_divisor  = sum_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   sfs_div #(
      .DW(DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // The table is read every cycle at the current frame; the frame never
   // changes in the cycle before S_LOAD, so the data there is current.
   always_ff @(posedge clock) begin
      rd_data_ff <= dur_mem[frame_now_ff[AW-1:0]];
      if (req_fire && (req_item.cmd == CMD_WRITE) &&
          (32'(req_item.frame_index) < MAX_FRAMES)) begin
         dur_mem[req_item.frame_index[AW-1:0]] <= DURATION_BITS'(req_item.duration_ms);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_UNITY;
         single_ff <= 1'b0;
         ftotal_ff <= COUNT_BITS'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SPEED:  speed_ff  <= csr_wdata[SPEED_BITS-1:0];
            CSR_SINGLE: single_ff <= csr_wdata[0];
            CSR_TOTAL:  ftotal_ff <= csr_wdata[COUNT_BITS-1:0];
            default:    speed_ff  <= speed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frame_now_ff <= '0;
         acc_ff       <= '0;
         running_ff   <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sum_ovf_ff   <= 1'b0;
      end else begin
         if (rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  fin_ff <= 1'b0;
                  case (req_item.cmd)
                     CMD_TICK: begin
                        elapsed_ff <= req_item.elapsed_ms;
                        loaded_ff  <= req_item.loaded_count;
                        cnt_ff     <= '0;
                        sum_ff     <= '0;
                        sum_ovf_ff <= 1'b0;
                        state_ff   <= running_ff ? S_LOAD : S_DONE;
                     end
                     CMD_START: begin
                        running_ff <= 1'b1;
                        state_ff   <= S_DONE;
                     end
                     CMD_STOP: begin
                        running_ff <= 1'b0;
                        state_ff   <= S_DONE;
                     end
                     CMD_RESET: begin
                        running_ff   <= 1'b0;
                        frame_now_ff <= '0;
                        acc_ff       <= '0;
                        state_ff     <= S_DONE;
                     end
                     CMD_SETF: begin
                        frame_now_ff <= req_item.frame_index;
                        state_ff     <= S_DONE;
                     end
                     default:   state_ff <= S_DONE;
                  endcase
               end
            end
            S_LOAD: begin
               state_ff <= (dur_eff == '0) ? S_ADD : S_SDIV;
            end
            S_SDIV: begin
               if (div_done) begin
                  s_ff     <= div_quo[ACC_BITS-1:0];
                  s_big_ff <= (div_quo >> ACC_BITS) != '0;
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               if (brk) begin
                  state_ff <= S_ADD;
               end else if (stop_shot) begin
                  running_ff <= 1'b0;
                  acc_ff     <= '0;
                  fin_ff     <= 1'b1;
                  state_ff   <= S_ADD;
               end else if (!adv) begin
                  state_ff <= S_MDIV;
               end else begin
                  acc_ff <= acc_ff - s_ff;
                  if (frame_ext < total_eff) begin
                     sum_ff     <= sum_in[ACC_BITS-1:0];
                     sum_ovf_ff <= sum_ovf_ff | sum_in[ACC_BITS];
                     cnt_ff     <= cnt_ff + COUNT_BITS'(1);
                  end
                  if (wrap_slow) begin
                     state_ff <= S_FDIV;
                  end else begin
                     frame_now_ff <= (frame_inc == total_eff) ? '0 : frame_inc[FRAME_BITS-1:0];
                     state_ff     <= S_CYC;
                  end
               end
            end
            S_MDIV: begin
               if (div_done) begin
                  acc_ff   <= div_rem + ACC_BITS'(1);
                  state_ff <= S_ADD;
               end
            end
            S_FDIV: begin
               if (div_done) begin
                  frame_now_ff <= div_rem[FRAME_BITS-1:0];
                  state_ff     <= S_CYC;
               end
            end
            S_CYC: begin
               if (cnt_ff == total_eff) begin
                  cnt_ff     <= '0;
                  sum_ff     <= '0;
                  sum_ovf_ff <= 1'b0;
               end
               state_ff <= cyc_mod ? S_CDIV : S_LOAD;
            end
            S_CDIV: begin
               if (div_done) begin
                  acc_ff   <= div_rem + ACC_BITS'(1);
                  state_ff <= S_LOAD;
               end
            end
            S_ADD: begin
               acc_ff   <= acc_sum_in[ACC_BITS] ? '1 : acc_sum_in[ACC_BITS-1:0];
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_item_ff.current_frame <= frame_now_ff;
         rsp_item_ff.playing       <= running_ff;
         rsp_item_ff.finished      <= fin_ff;
      end
   end

`ifndef SYNTH
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_SDIV || state_ff == S_FDIV ||
                    state_ff == S_MDIV || state_ff == S_CDIV))
      else $error("divider finished while no state waits for it");

   a_finished_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.finished |-> !rsp_item_ff.playing)
      else $error("finished beat reports playback still running");

   a_stop_clears_run: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_item.cmd == CMD_STOP) |=> !running_ff)
      else $error("stop command left playback running");

   a_loop_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |-> cnt_ff < total_eff)
      else $error("loop frame count passed the frame total");
`endif

endmodule

// ----- tb/tb_sprite_frame_sequencer.sv -----
module tb_sprite_frame_sequencer;
   import sfs_pkg::*;

   localparam int SEQ_FRAMES     = 256;
   localparam int STEP_CAP       = 300;
   localparam int BACKLOG_DEPTH  = 4;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int PRESSURE_PHASE = 4;
   localparam int PAUSE_PHASE    = 5;
   localparam int SATURATE_PHASE = 6;

   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE = 2'd3;

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_item  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_item;
   logic                     csr_we    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr  = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   sprite_frame_sequencer #(
      .MAX_FRAMES(SEQ_FRAMES),
      .DURATION_BITS(16)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   // Predicted sequencer state.
   bit [15:0]   dur_mem [SEQ_FRAMES];
   bit          dur_written [SEQ_FRAMES];
   logic [7:0]  frame_q;
   logic [31:0] accum_q;
   bit          run_q;
   logic [11:0] speed_q;
   bit          single_q;
   logic [8:0]  total_q;

   req_type cmd_backlog [$];
   rsp_type status_due [$];
   int      mismatch_count = 0;
   int      send_idle = 0;
   int      recv_stall = 0;
   int      hold_asks = 0;
   int      hold_seen = 0;
   int      hold_left = 0;
   logic    req_took = 1'b0;
   rsp_type want;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int frame_count();
      int t;
      t = total_q;
      if (t == 0) t = 1;
      if (t > SEQ_FRAMES) t = SEQ_FRAMES;
      return t;
   endfunction

   function automatic longint unsigned scaled_ms_q8(input int idx);
      longint unsigned sp, d;
      if (idx >= SEQ_FRAMES) return 0;
      sp = speed_q;
      if (sp == 0) sp = 1;
      d = dur_mem[idx];
      return (d << 16) / sp;
   endfunction

   // Catch-up over whole frames, then the elapsed time is added. steps counts
   // frame advances so that runaway ticks can be kept out of the stimulus.
   function automatic bit consume_time(input logic [15:0] el, input logic [8:0] ld,
                                       output int steps);
      longint unsigned acc, sum, s, e;
      int total, f;
      bit fin, ok;
      total = frame_count();
      acc = accum_q;
      fin = 0;
      steps = 0;
      if (!single_q && int'(ld) >= total && int'(frame_q) < total) begin
         sum = 0;
         ok = 1;
         for (f = 0; f < total && ok; f++) begin
            s = scaled_ms_q8(f);
            if (s == 0) ok = 0;
            else sum += s;
         end
         if (ok && acc > sum) acc -= ((acc - 1) / sum) * sum;
      end
      while (steps <= STEP_CAP) begin
         s = scaled_ms_q8(frame_q);
         if (s == 0 || acc <= s) break;
         if (int'(frame_q) == total - 1 && single_q) begin
            run_q = 0;
            acc = 0;
            fin = 1;
            break;
         end
         if (!(int'(ld) == total || int'(frame_q) < int'(ld) - 1)) begin
            // The frame holds: drop whole durations but keep the remainder.
            acc -= ((acc - 1) / s) * s;
            break;
         end
         acc -= s;
         frame_q = 8'((int'(frame_q) + 1) % total);
         steps++;
      end
      e = el;
      acc += e << 8;
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      accum_q = acc[31:0];
      return fin;
   endfunction

   function automatic rsp_type play_step(input req_type it, output int steps);
      rsp_type r;
      bit fin;
      fin = 0;
      steps = 0;
      case (it.cmd)
         CMD_TICK:  if (run_q) fin = consume_time(it.elapsed_ms, it.loaded_count, steps);
         CMD_START: run_q = 1;
         CMD_STOP:  run_q = 0;
         CMD_RESET: begin
            run_q = 0;
            frame_q = '0;
            accum_q = '0;
         end
         CMD_SETF:  frame_q = it.frame_index;
         CMD_WRITE: begin
            dur_mem[it.frame_index] = it.duration_ms;
            dur_written[it.frame_index] = 1;
         end
         default: ;
      endcase
      r.current_frame = frame_q;
      r.playing = run_q;
      r.finished = fin;
      return r;
   endfunction

   function automatic logic [15:0] random_span(input int typical);
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return 16'd0;
      if (pick < 15) return 16'hFFFF;
      if (pick < 75) return 16'($urandom_range(typical, 1));
      return 16'($urandom);
   endfunction

   function automatic req_type random_item();
      req_type it;
      int pick, total;
      total = frame_count();
      it.elapsed_ms = random_span(100);
      it.duration_ms = random_span(64);
      it.frame_index = ($urandom_range(99) < 75) ? 8'($urandom_range(total - 1))
                                                 : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 60) it.loaded_count = 9'(total);
      else if (pick < 75) it.loaded_count = 9'($urandom_range(total));
      else if (pick < 85) it.loaded_count = '0;
      else if (pick < 95) it.loaded_count = 9'($urandom_range(256, total));
      else it.loaded_count = 9'($urandom_range(511));
      pick = $urandom_range(99);
      if (pick < 50) it.cmd = CMD_TICK;
      else if (pick < 60) it.cmd = CMD_START;
      else if (pick < 65) it.cmd = CMD_STOP;
      else if (pick < 69) it.cmd = CMD_RESET;
      else if (pick < 77) it.cmd = CMD_SETF;
      else if (pick < 94) it.cmd = CMD_WRITE;
      else it.cmd = pick[0] ? CMD_SPARE_A : CMD_SPARE_B;
      return it;
   endfunction

   // A running tick reads the durations of every frame below the count and of
   // the current frame, so any of those never written are loaded first.
   task automatic send_item(input req_type it);
      req_type fill;
      rsp_type status;
      logic [7:0] keep_frame;
      logic [31:0] keep_accum;
      bit keep_run;
      int f, total, steps;
      if (it.cmd == CMD_TICK && run_q) begin
         total = frame_count();
         for (f = 0; f < SEQ_FRAMES; f++) begin
            if (!dur_written[f] && (f < total || f == int'(frame_q))) begin
               fill = '0;
               fill.cmd = CMD_WRITE;
               fill.frame_index = 8'(f);
               fill.duration_ms = random_span(64);
               send_item(fill);
            end
         end
      end
      keep_frame = frame_q;
      keep_accum = accum_q;
      keep_run = run_q;
      status = play_step(it, steps);
      if (steps > STEP_CAP) begin
         // Far too many laps for one tick; jump back to frame zero instead.
         frame_q = keep_frame;
         accum_q = keep_accum;
         run_q = keep_run;
         it = '0;
         it.cmd = CMD_SETF;
         status = play_step(it, steps);
      end
      while (cmd_backlog.size() >= BACKLOG_DEPTH) @(posedge clock);
      cmd_backlog.push_back(it);
      status_due.push_back(status);
   endtask

   task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] el,
                           input logic [7:0] idx, input logic [15:0] dur,
                           input logic [8:0] ld);
      req_type it;
      it.cmd = cmd;
      it.elapsed_ms = el;
      it.frame_index = idx;
      it.duration_ms = dur;
      it.loaded_count = ld;
      send_item(it);
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_valid || status_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_SPEED:  speed_q = data;
         CSR_SINGLE: single_q = data[0];
         CSR_TOTAL:  total_q = data[8:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input int ph, input logic [11:0] speed, input bit single,
                            input logic [8:0] total, input int count);
      int n;
      wait_drained();
      case (ph % 4)
         0: begin
            send_idle = 0;
            recv_stall = 0;
         end
         1: begin
            send_idle = 87;
            recv_stall = 0;
         end
         2: begin
            send_idle = 0;
            recv_stall = 87;
         end
         default: begin
            send_idle = 27;
            recv_stall = 27;
         end
      endcase
      write_csr(CSR_SPEED, speed);
      write_csr(CSR_SINGLE, {11'($urandom), single});
      write_csr(CSR_TOTAL, {3'($urandom), total});
      if (ph == SATURATE_PHASE) begin
         // Park on a zero-length frame until the accumulator pins at its top.
         send_cmd(CMD_WRITE, 16'd0, 8'd0, 16'd0, 9'd0);
         send_cmd(CMD_WRITE, 16'd0, 8'd1, 16'd7, 9'd0);
         send_cmd(CMD_START, 16'd0, 8'd0, 16'd0, 9'd0);
         send_cmd(CMD_SETF, 16'd0, 8'd0, 16'd0, 9'd0);
         for (n = 0; n < 260; n++) send_cmd(CMD_TICK, 16'hFFFF, 8'd0, 16'd0, 9'd2);
         send_cmd(CMD_WRITE, 16'd0, 8'd0, 16'd3, 9'd0);
         send_cmd(CMD_TICK, 16'd0, 8'd0, 16'd0, 9'd2);
      end
      for (n = 0; n < count; n++) begin
         if (ph == PRESSURE_PHASE && n == 30) hold_asks++;
         if (ph == PAUSE_PHASE && n == count / 2) wait_drained();
         send_item(random_item());
      end
   endtask

   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_item <= cmd_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due.size() == 0) begin
            $display("%0t: status beat with nothing expected: %p", $time, rsp_item);
            mismatch_count++;
         end else begin
            want = status_due.pop_front();
            if (rsp_item.current_frame !== want.current_frame) begin
               $display("%0t: current_frame expected %0d, got %0d", $time,
                        want.current_frame, rsp_item.current_frame);
               mismatch_count++;
            end
            if (rsp_item.playing !== want.playing) begin
               $display("%0t: playing expected %0b, got %0b", $time,
                        want.playing, rsp_item.playing);
               mismatch_count++;
            end
            if (rsp_item.finished !== want.finished) begin
               $display("%0t: finished expected %0b, got %0b", $time,
                        want.finished, rsp_item.finished);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((cmd_backlog.size() != 0 || status_due.size() != 0 || req_valid) &&
             !(req_valid && req_ready) && !(rsp_valid && rsp_ready))
            quiet_cycles++;
         else
            quiet_cycles = 0;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      frame_q = '0;
      accum_q = '0;
      run_q = 0;
      speed_q = SPEED_UNITY;
      single_q = 0;
      total_q = 9'd1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(CSR_SPARE, 12'($urandom));
      write_csr(CSR_SPEED, SPEED_UNITY);
      write_csr(CSR_TOTAL, 12'd4);
      send_cmd(CMD_WRITE, 16'd0, 8'd0, 16'd10, 9'd0);
      send_cmd(CMD_WRITE, 16'd0, 8'd1, 16'd0, 9'd0);
      send_cmd(CMD_WRITE, 16'd0, 8'd2, 16'hFFFF, 9'd0);
      send_cmd(CMD_WRITE, 16'd0, 8'd3, 16'd1, 9'd0);
      send_cmd(CMD_WRITE, 16'd0, 8'd255, 16'd5, 9'd0);
      send_cmd(CMD_START, 16'd0, 8'd0, 16'd0, 9'd0);
      send_cmd(CMD_TICK, 16'hFFFF, 8'd0, 16'd0, 9'd4);
      send_cmd(CMD_TICK, 16'd0, 8'd0, 16'd0, 9'd4);
      send_cmd(CMD_SETF, 16'd0, 8'd3, 16'd0, 9'd0);
      send_cmd(CMD_TICK, 16'd0, 8'd0, 16'd0, 9'd4);
      // Frame beyond the count, with nothing loaded and then partly loaded.
      send_cmd(CMD_SETF, 16'd0, 8'd255, 16'd0, 9'd0);
      send_cmd(CMD_TICK, 16'd1, 8'd0, 16'd0, 9'd0);
      send_cmd(CMD_TICK, 16'd0, 8'd0, 16'd0, 9'd2);
      send_cmd(CMD_SETF, 16'd0, 8'd0, 16'd0, 9'd0);
      send_cmd(CMD_TICK, 16'hFFFF, 8'd0, 16'd0, 9'd1);
      send_cmd(CMD_TICK, 16'd0, 8'd0, 16'd0, 9'd1);
      send_cmd(CMD_SPARE_A, 16'hFFFF, 8'hFF, 16'hFFFF, 9'h1FF);
      send_cmd(CMD_SPARE_B, 16'd0, 8'd0, 16'd0, 9'd0);
      send_cmd(CMD_STOP, 16'd0, 8'd0, 16'd0, 9'd0);
      send_cmd(CMD_TICK, 16'hFFFF, 8'd0, 16'd0, 9'h1FF);
      send_cmd(CMD_RESET, 16'd0, 8'd0, 16'd0, 9'd0);
      send_cmd(CMD_START, 16'd0, 8'd0, 16'd0, 9'd0);
      send_cmd(CMD_TICK, 16'd30, 8'd0, 16'd0, 9'd4);
      send_cmd(CMD_TICK, 16'd30, 8'd0, 16'd0, 9'd300);

      run_phase(0, SPEED_UNITY, 1'b0, 9'd4, 180);
      run_phase(1, 12'd4095, 1'b0, 9'd6, 160);
      run_phase(2, 12'd1, 1'b0, 9'd3, 140);
      run_phase(3, 12'd4095, 1'b1, 9'd5, 160);
      run_phase(4, 12'($urandom_range(4095, 1)), 1'b1, 9'd1, 120);
      run_phase(5, 12'($urandom_range(4095, 1)), 1'b0, 9'd8, 180);
      run_phase(6, 12'd0, 1'b0, 9'd2, 100);
      run_phase(7, 12'($urandom_range(4095, 1)), 1'b1, 9'd16, 160);
      run_phase(8, 12'($urandom_range(4095, 1)), 1'b0, 9'd256, 40);
      run_phase(9, 12'($urandom_range(4095, 1)), 1'b0, 9'd0, 60);
      run_phase(10, 12'($urandom_range(4095, 1)), 1'b1, 9'd511, 30);
      run_phase(11, SPEED_UNITY, 1'b0, 9'd12, 200);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
